// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the calendar converter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("calendar converter assertion failed");

// Condition that must never hold outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `ASSERT_CLK(lbl, clk, rst_n, !(cond))

`endif

// ===== src/esc_pkg.sv =====
// ----------------------------------------------------------------------------
// esc_pkg
// Types, constants and calendar helper functions of the epoch converter.
// ----------------------------------------------------------------------------
`default_nettype none

package esc_pkg;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEC,
    ST_MIN,
    ST_HOUR,
    ST_WDAY,
    ST_YEAR,
    ST_MONTH
  } esc_state_e;

  // Datapath operations.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_MUL,
    OP_DIV,
    OP_YEAR,
    OP_MONTH,
    OP_OUT
  } esc_op_e;

  // Which constant division pass is running.
  typedef enum logic [1:0] {
    DIV_SEC,
    DIV_MIN,
    DIV_HOUR,
    DIV_WDAY
  } esc_div_e;

  // Command from controller to datapath.
  typedef struct packed {
    esc_op_e    op;
    esc_div_e   dsel;
  } esc_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic year_done;
    logic month_done;
  } esc_stat_t;

  // One result item.
  typedef struct packed {
    logic [4:0] day_of_month;
    logic [3:0] month_number;
    logic [7:0] year_offset;
    logic [2:0] weekday;
    logic [4:0] hour_of_day;
    logic [5:0] minute_of_hour;
    logic [5:0] second_of_minute;
  } esc_result_t;

  // Divisors of the four division passes.
  localparam logic [5:0] SEC_PER_MIN   = 6'd60;
  localparam logic [5:0] MIN_PER_HOUR  = 6'd60;
  localparam logic [5:0] HOUR_PER_DAY  = 6'd24;
  localparam logic [5:0] DAY_PER_WEEK  = 6'd7;

  // Rounded-up reciprocals. The quotient is the product shifted right by
  // 37 for 60, 36 for 24 and 34 for 7; the rounding error stays small enough
  // to be exact over the whole dividend range of each pass.
  localparam logic [31:0] RECIP_60 = 32'h8888_8889;
  localparam logic [31:0] RECIP_24 = 32'hAAAA_AAAB;
  localparam logic [31:0] RECIP_7  = 32'd2454267027;

  // 1970-01-01 was a Thursday, four days after a Sunday.
  localparam logic [15:0] WDAY_OFFSET = 16'd4;

  localparam logic [11:0] EPOCH_YEAR  = 12'd1970;
  localparam logic [3:0]  LAST_MONTH  = 4'd11;

  // Gregorian leap rule for 1970 plus an 8-bit offset (1970 to 2225).
  // The centuries in that span are 2000 (leap), 2100 and 2200 (not leap).
  function automatic logic is_leap(input logic [7:0] off);
    logic [11:0] y;
    y = EPOCH_YEAR + {4'b0, off};
    return (y[1:0] == 2'b00) && (y != 12'd2100) && (y != 12'd2200);
  endfunction

  // Days in a month, month counted from 0.
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      4'd1:                      len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== src/esc_ctrl.sv =====
// ----------------------------------------------------------------------------
// esc_ctrl
// Sequencer of the converter: steps the division passes, the year and month
// loops and manages the input and output handshakes.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module esc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire esc_pkg::esc_stat_t stat_i,
  output esc_pkg::esc_cmd_t      cmd_o
);
  import esc_pkg::*;

  esc_state_e state_q, state_d;
  logic       phase_q, phase_d;
  logic       out_valid_q, out_valid_d;
  logic       in_fire;

  // State, pass phase and result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign in_fire     = in_valid_i && in_ready_o;

  // Next state and datapath command. Each division pass first multiplies by the
  // reciprocal and then takes quotient and remainder from the registered product.
  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    cmd_o.op   = OP_NOP;
    cmd_o.dsel = DIV_SEC;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_SEC;
          phase_d  = 1'b0;
        end
      end
      ST_SEC: begin
        phase_d = !phase_q;
        if (phase_q) begin
          cmd_o.op = OP_DIV;
          state_d  = ST_MIN;
        end else begin
          cmd_o.op = OP_MUL;
        end
      end
      ST_MIN: begin
        cmd_o.dsel = DIV_MIN;
        phase_d    = !phase_q;
        if (phase_q) begin
          cmd_o.op = OP_DIV;
          state_d  = ST_HOUR;
        end else begin
          cmd_o.op = OP_MUL;
        end
      end
      ST_HOUR: begin
        cmd_o.dsel = DIV_HOUR;
        phase_d    = !phase_q;
        if (phase_q) begin
          cmd_o.op = OP_DIV;
          state_d  = ST_WDAY;
        end else begin
          cmd_o.op = OP_MUL;
        end
      end
      ST_WDAY: begin
        cmd_o.dsel = DIV_WDAY;
        phase_d    = !phase_q;
        if (phase_q) begin
          cmd_o.op = OP_DIV;
          state_d  = ST_YEAR;
        end else begin
          cmd_o.op = OP_MUL;
        end
      end
      ST_YEAR: begin
        if (stat_i.year_done) begin
          state_d = ST_MONTH;
        end else begin
          cmd_o.op = OP_YEAR;
        end
      end
      ST_MONTH: begin
        // Hand the result over only when the output register is free.
        if (!stat_i.month_done) begin
          cmd_o.op = OP_MONTH;
        end else if (!out_valid_q || out_ready_i) begin
          cmd_o.op = OP_OUT;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // The output register is loaded or drained.
  always_comb begin
    out_valid_d = out_valid_q;
    priority if (cmd_o.op == OP_OUT) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  `ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni,
                out_valid_q && !out_ready_i && (cmd_o.op == OP_OUT))
  `ASSERT_CLK(a_accept_starts, clk_i, rst_ni,
              in_fire |=> (state_q == ST_SEC) && !phase_q)
  `ASSERT_CLK(a_finish_shows, clk_i, rst_ni,
              (state_q == ST_MONTH) && stat_i.month_done && !out_valid_q
              |=> (state_q == ST_IDLE) && out_valid_q)

endmodule

`default_nettype wire

// ===== src/esc_datapath.sv =====
// ----------------------------------------------------------------------------
// esc_datapath
// Reciprocal multiplier for the constant divisions, year and month
// subtractors and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_datapath (
  input  wire logic                clk_i,
  input  wire logic [31:0]         epoch_seconds_i,
  input  wire esc_pkg::esc_cmd_t   cmd_i,
  output esc_pkg::esc_stat_t       stat_o,
  output esc_pkg::esc_result_t     result_o
);
  import esc_pkg::*;

  logic [31:0] w_q, w_d;
  logic [63:0] prod_q, prod_d;
  logic [15:0] days_q, days_d;
  logic [7:0]  year_q, year_d;
  logic [3:0]  month_q, month_d;
  logic [5:0]  sec_q, sec_d;
  logic [5:0]  min_q, min_d;
  logic [4:0]  hr_q, hr_d;
  logic [2:0]  wday_q, wday_d;
  esc_result_t res_q, res_d;

  logic [5:0]  dvs;
  logic [31:0] recip;
  logic [31:0] quot;
  logic [5:0]  rem;
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;

  // Divisor, reciprocal and quotient of the current pass.
  always_comb begin
    unique case (cmd_i.dsel)
      DIV_SEC: begin
        dvs   = SEC_PER_MIN;
        recip = RECIP_60;
        quot  = {5'b0, prod_q[63:37]};
      end
      DIV_MIN: begin
        dvs   = MIN_PER_HOUR;
        recip = RECIP_60;
        quot  = {5'b0, prod_q[63:37]};
      end
      DIV_HOUR: begin
        dvs   = HOUR_PER_DAY;
        recip = RECIP_24;
        quot  = {4'b0, prod_q[63:36]};
      end
      DIV_WDAY: begin
        dvs   = DAY_PER_WEEK;
        recip = RECIP_7;
        quot  = {2'b0, prod_q[63:34]};
      end
      default: begin
        dvs   = SEC_PER_MIN;
        recip = RECIP_60;
        quot  = {5'b0, prod_q[63:37]};
      end
    endcase
  end

  // The remainder is below 64, so the low six bits of the difference suffice.
  assign rem = w_q[5:0] - quot[5:0] * dvs;

  // Year and month lengths for the current counters.
  assign leap = is_leap(year_q);
  assign ylen = leap ? 9'd366 : 9'd365;
  assign mlen = month_len(month_q, leap);

  assign stat_o.year_done  = (days_q < {7'b0, ylen});
  assign stat_o.month_done = (month_q == LAST_MONTH) || (days_q < {11'b0, mlen});

  // Operation decode.
  always_comb begin
    w_d     = w_q;
    prod_d  = prod_q;
    days_d  = days_q;
    year_d  = year_q;
    month_d = month_q;
    sec_d   = sec_q;
    min_d   = min_q;
    hr_d    = hr_q;
    wday_d  = wday_q;
    res_d   = res_q;
    unique case (cmd_i.op)
      OP_LOAD: begin
        w_d     = epoch_seconds_i;
        year_d  = '0;
        month_d = '0;
      end
      OP_MUL: begin
        prod_d = {32'b0, w_q} * {32'b0, recip};
      end
      OP_DIV: begin
        // The remainder is the field; the quotient feeds the next pass.
        w_d = quot;
        unique case (cmd_i.dsel)
          DIV_SEC:  sec_d  = rem;
          DIV_MIN:  min_d  = rem;
          DIV_HOUR: begin
            hr_d   = rem[4:0];
            days_d = quot[15:0];
            w_d    = {16'b0, quot[15:0] + WDAY_OFFSET};
          end
          DIV_WDAY: wday_d = rem[2:0] + 3'd1;
          default:  sec_d  = rem;
        endcase
      end
      OP_YEAR: begin
        days_d = days_q - {7'b0, ylen};
        year_d = year_q + 8'd1;
      end
      OP_MONTH: begin
        days_d  = days_q - {11'b0, mlen};
        month_d = month_q + 4'd1;
      end
      OP_OUT: begin
        res_d.second_of_minute = sec_q;
        res_d.minute_of_hour   = min_q;
        res_d.hour_of_day      = hr_q;
        res_d.weekday          = wday_q;
        res_d.year_offset      = year_q;
        res_d.month_number     = month_q + 4'd1;
        res_d.day_of_month     = days_q[4:0] + 5'd1;
      end
      default: begin
        w_d = w_q;
      end
    endcase
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    w_q     <= w_d;
    prod_q  <= prod_d;
    days_q  <= days_d;
    year_q  <= year_d;
    month_q <= month_d;
    sec_q   <= sec_d;
    min_q   <= min_d;
    hr_q    <= hr_d;
    wday_q  <= wday_d;
    res_q   <= res_d;
  end

  assign result_o = res_q;

endmodule

`default_nettype wire

// ===== src/epoch_seconds_to_calendar.sv =====
// A 32-bit count of seconds since 1970-01-01 00:00:00 enters on the slave
// stream and one calendar breakdown leaves on the master stream. The block
// works on one item at a time: it takes an item only while its sequencer is
// idle, and the finished result waits in an output register, so a new item
// may be accepted while the previous result is still pending. After
// acceptance, a shared reciprocal multiplier performs the second, minute,
// hour and weekday divisions in turn, each as a multiply step followed by
// a quotient and remainder step; the year loop then subtracts whole years
// from the day count and the month loop whole months, and the result is
// loaded into the output register once that register is free.
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Top level: Unix time to Gregorian date and time of day.
// ----------------------------------------------------------------------------
`default_nettype none

module epoch_seconds_to_calendar (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // [31:0] epoch_seconds
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [5:0] second_of_minute, [11:6] minute_of_hour, [16:12] hour_of_day,
  // [19:17] weekday, [27:20] year_offset, [31:28] month_number,
  // [36:32] day_of_month, [39:37] zero
  output logic [39:0]      m_axis_tdata
);
  import esc_pkg::*;

  esc_cmd_t    cmd;
  esc_stat_t   stat;
  esc_result_t result;

  esc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  esc_datapath u_datapath (
    .clk_i           (clk_i),
    .epoch_seconds_i (s_axis_tdata),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .result_o        (result)
  );

  // The result struct is already ordered with the last field lowest.
  assign m_axis_tdata = {3'b000, result};

endmodule

`default_nettype wire
